/* hdl/bsoc_pkg.sv */
`timescale 1ns / 1ps

package bsoc_pkg;

    localparam logic [6:0] FULL_PERCENT = 7'd100;
    localparam logic [6:0] FIRST_CAP_PERCENT = 7'd99;

    localparam logic KIND_GAUGE   = 1'b0;
    localparam logic KIND_CHARGER = 1'b1;

    typedef enum logic [1:0] {
        MODE_DISCHARGING = 2'd0,
        MODE_CHARGING    = 2'd1,
        MODE_DONE        = 2'd2,
        MODE_UNKNOWN     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DISCHARGING = 2'd0,
        ST_CHARGING    = 2'd1,
        ST_FULL        = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        LVL_CRITICAL = 2'd0,
        LVL_NORMAL   = 2'd1,
        LVL_FULL     = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        REG_UPDATE_PERIOD   = 3'd0,
        REG_LONG_PERIOD     = 3'd1,
        REG_MAX_DROP        = 3'd2,
        REG_CRITICAL_LOW_MV = 3'd3,
        REG_DEAD_MV         = 3'd4,
        REG_FORCED_DROP     = 3'd5,
        REG_LOW_LEVEL       = 3'd6,
        REG_COMPLETE_CANCEL = 3'd7
    } reg_index_t;

    localparam logic [31:0] RST_UPDATE_PERIOD   = 32'd59000;
    localparam logic [31:0] RST_LONG_PERIOD     = 32'd3599000;
    localparam logic [6:0]  RST_MAX_DROP        = 7'd2;
    localparam logic [12:0] RST_CRITICAL_LOW_MV = 13'd3450;
    localparam logic [12:0] RST_DEAD_MV         = 13'd3400;
    localparam logic [6:0]  RST_FORCED_DROP     = 7'd6;
    localparam logic [6:0]  RST_LOW_LEVEL       = 7'd15;
    localparam logic [6:0]  RST_COMPLETE_CANCEL = 7'd96;

    typedef struct packed {
        logic [31:0] update_period_ms;
        logic [31:0] long_period_ms;
        logic [6:0]  max_drop_per_update;
        logic [12:0] critical_low_mv;
        logic [12:0] dead_mv;
        logic [6:0]  forced_drop;
        logic [6:0]  low_level_percent;
        logic [6:0]  complete_cancel_percent;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] raw_soc_word;
        logic [15:0] cell_voltage_word;
        logic [31:0] elapsed_ms;
        logic [1:0]  charger_event;
    } item_t;

    // first member in the highest bits, so reported_percent lands at bit 0
    typedef struct packed {
        logic       fast_poll;
        logic       notify;
        logic       percent_updated;
        logic       health_dead;
        logic [1:0] charge_level;
        logic [1:0] supply_status;
        logic [6:0] reported_percent;
    } result_t;

endpackage

/* hdl/bsoc_cfg.sv */
`timescale 1ns / 1ps

module bsoc_cfg
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [31:0]     cfg_wdata,
    output bsoc_pkg::cfg_t  cfg
);

    bsoc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_period_ms        <= bsoc_pkg::RST_UPDATE_PERIOD;
            cfg_reg.long_period_ms          <= bsoc_pkg::RST_LONG_PERIOD;
            cfg_reg.max_drop_per_update     <= bsoc_pkg::RST_MAX_DROP;
            cfg_reg.critical_low_mv         <= bsoc_pkg::RST_CRITICAL_LOW_MV;
            cfg_reg.dead_mv                 <= bsoc_pkg::RST_DEAD_MV;
            cfg_reg.forced_drop             <= bsoc_pkg::RST_FORCED_DROP;
            cfg_reg.low_level_percent       <= bsoc_pkg::RST_LOW_LEVEL;
            cfg_reg.complete_cancel_percent <= bsoc_pkg::RST_COMPLETE_CANCEL;
        end
        else if (cfg_we)
        begin
            case (bsoc_pkg::reg_index_t'(cfg_index))
                bsoc_pkg::REG_UPDATE_PERIOD:   cfg_reg.update_period_ms <= cfg_wdata;
                bsoc_pkg::REG_LONG_PERIOD:     cfg_reg.long_period_ms <= cfg_wdata;
                bsoc_pkg::REG_MAX_DROP:        cfg_reg.max_drop_per_update <= cfg_wdata[6:0];
                bsoc_pkg::REG_CRITICAL_LOW_MV: cfg_reg.critical_low_mv <= cfg_wdata[12:0];
                bsoc_pkg::REG_DEAD_MV:         cfg_reg.dead_mv <= cfg_wdata[12:0];
                bsoc_pkg::REG_FORCED_DROP:     cfg_reg.forced_drop <= cfg_wdata[6:0];
                bsoc_pkg::REG_LOW_LEVEL:       cfg_reg.low_level_percent <= cfg_wdata[6:0];
                bsoc_pkg::REG_COMPLETE_CANCEL: cfg_reg.complete_cancel_percent <= cfg_wdata[6:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/bsoc_core.sv */
`timescale 1ns / 1ps

module bsoc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  bsoc_pkg::cfg_t      cfg,
    input  bsoc_pkg::item_t     item,
    input  logic                advance,
    output bsoc_pkg::result_t   res
);

    logic [6:0]  shown_reg,       shown_next;
    logic [6:0]  previous_reg,    previous_next;
    logic [8:0]  raw_pct_reg,     raw_pct_next;
    logic        first_done_reg,  first_done_next;
    bsoc_pkg::mode_t   mode_reg,  mode_next;
    logic        complete_reg,    complete_next;
    bsoc_pkg::status_t status_next;
    bsoc_pkg::status_t prev_status_reg, prev_status_next;
    bsoc_pkg::level_t  level_reg, level_next;
    logic        dead_reg,        dead_next;
    logic [31:0] time_reg,        time_next;

    logic [8:0]  raw_pct;
    logic [32:0] time_sum;
    logic [31:0] time_sat;
    logic [15:0] mv_x5;
    logic [12:0] mv;
    logic [6:0]  init_pct;
    logic [6:0]  prev_pct;
    logic [6:0]  shown_base;
    logic [8:0]  target_raw;
    logic [6:0]  target;
    logic [6:0]  dec;
    logic [6:0]  smoothed;
    logic        updated;
    logic        discharging;
    logic        pct_notify;

    function automatic bsoc_pkg::status_t status_of(bsoc_pkg::mode_t m, logic [6:0] pct,
                                                    logic done);
        bsoc_pkg::status_t s;
        if (m == bsoc_pkg::MODE_DISCHARGING || m == bsoc_pkg::MODE_UNKNOWN)
            s = bsoc_pkg::ST_DISCHARGING;
        else if (pct >= bsoc_pkg::FULL_PERCENT && done)
            s = bsoc_pkg::ST_FULL;
        else
            s = bsoc_pkg::ST_CHARGING;
        return s;
    endfunction

    // gauge sample datapath
    always_comb
    begin
        raw_pct  = {1'b0, item.raw_soc_word[15:8]} + {8'd0, |item.raw_soc_word[7:0]};
        time_sum = {1'b0, time_reg} + {1'b0, item.elapsed_ms};
        time_sat = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
        // (w >> 3) * 625 / 1000 is exactly (w >> 3) * 5 / 8
        mv_x5    = {3'd0, item.cell_voltage_word[15:3]}
                 + {1'b0, item.cell_voltage_word[15:3], 2'd0};
        mv       = mv_x5[15:3];

        init_pct   = (raw_pct >= {2'd0, bsoc_pkg::FULL_PERCENT}) ?
                     bsoc_pkg::FIRST_CAP_PERCENT : raw_pct[6:0];
        prev_pct   = first_done_reg ? previous_reg : init_pct;
        shown_base = first_done_reg ? shown_reg : init_pct;

        if (complete_reg)
            target_raw = {2'd0, bsoc_pkg::FULL_PERCENT};
        else if (raw_pct >= {2'd0, bsoc_pkg::FULL_PERCENT} && prev_pct < bsoc_pkg::FULL_PERCENT)
            target_raw = {2'd0, bsoc_pkg::FIRST_CAP_PERCENT};
        else
            target_raw = raw_pct;
        target = (target_raw > {2'd0, bsoc_pkg::FULL_PERCENT}) ?
                 bsoc_pkg::FULL_PERCENT : target_raw[6:0];

        dec = (prev_pct > target) ? prev_pct - target : 7'd0;
        if (dec > cfg.max_drop_per_update)
            dec = cfg.max_drop_per_update;

        discharging = (mode_reg == bsoc_pkg::MODE_DISCHARGING) ||
                      (mode_reg == bsoc_pkg::MODE_UNKNOWN);
        updated  = 1'b1;
        smoothed = target;
        if (discharging)
        begin
            if (mv >= cfg.critical_low_mv)
            begin
                if (time_sat >= cfg.long_period_ms)
                    smoothed = (target > prev_pct) ? prev_pct : target;
                else if (time_sat < cfg.update_period_ms)
                    updated = 1'b0;
                else
                    smoothed = prev_pct - dec;
            end
            else if (mv < cfg.dead_mv)
                smoothed = 7'd0;
            else
                smoothed = (prev_pct <= cfg.forced_drop) ? 7'd0 : prev_pct - cfg.forced_drop;
        end
        else if (target > prev_pct)
            smoothed = prev_pct + 7'd1;
    end

    // next state for both kinds of transfer
    always_comb
    begin
        shown_next      = shown_reg;
        previous_next   = previous_reg;
        raw_pct_next    = raw_pct_reg;
        first_done_next = first_done_reg;
        mode_next       = mode_reg;
        complete_next   = complete_reg;
        level_next      = level_reg;
        dead_next       = dead_reg;
        time_next       = time_reg;
        pct_notify      = 1'b0;

        if (item.kind == bsoc_pkg::KIND_GAUGE)
        begin
            raw_pct_next    = raw_pct;
            first_done_next = 1'b1;
            shown_next      = updated ? smoothed : shown_base;
            time_next       = updated ? 32'd0 : time_sat;
            previous_next   = prev_pct;
            if (shown_next != prev_pct)
            begin
                previous_next = shown_next;
                pct_notify    = (shown_next >= bsoc_pkg::FULL_PERCENT) || (shown_next == 7'd0);
            end
            status_next = status_of(mode_reg, shown_next, complete_reg);
            if (shown_next >= bsoc_pkg::FULL_PERCENT)
            begin
                level_next = bsoc_pkg::LVL_FULL;
                dead_next  = 1'b0;
            end
            else if (shown_next < cfg.low_level_percent)
            begin
                level_next = bsoc_pkg::LVL_CRITICAL;
                dead_next  = 1'b1;
            end
            else
            begin
                level_next = bsoc_pkg::LVL_NORMAL;
                dead_next  = 1'b0;
            end
        end
        else
        begin
            mode_next = bsoc_pkg::mode_t'(item.charger_event);
            if (mode_next == bsoc_pkg::MODE_DONE)
                complete_next = 1'b1;
            else if (mode_next != bsoc_pkg::MODE_CHARGING ||
                     raw_pct_reg < {2'd0, cfg.complete_cancel_percent})
                complete_next = 1'b0;
            status_next = status_of(mode_next, shown_reg, complete_next);
        end

        // current status only lives in the result, the register keeps the previous one
        prev_status_next = status_next;

        res.reported_percent = shown_next;
        res.supply_status    = status_next;
        res.charge_level     = level_next;
        res.health_dead      = dead_next;
        res.percent_updated  = (item.kind == bsoc_pkg::KIND_GAUGE) && updated;
        res.notify           = pct_notify || (status_next != prev_status_reg);
        res.fast_poll        = (status_next != bsoc_pkg::ST_DISCHARGING);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg       <= 7'd0;
            previous_reg    <= 7'd0;
            raw_pct_reg     <= 9'd0;
            first_done_reg  <= 1'b0;
            mode_reg        <= bsoc_pkg::MODE_DISCHARGING;
            complete_reg    <= 1'b0;
            prev_status_reg <= bsoc_pkg::ST_DISCHARGING;
            level_reg       <= bsoc_pkg::LVL_CRITICAL;
            dead_reg        <= 1'b0;
            time_reg        <= 32'd0;
        end
        else if (advance)
        begin
            shown_reg       <= shown_next;
            previous_reg    <= previous_next;
            raw_pct_reg     <= raw_pct_next;
            first_done_reg  <= first_done_next;
            mode_reg        <= mode_next;
            complete_reg    <= complete_next;
            prev_status_reg <= prev_status_next;
            level_reg       <= level_next;
            dead_reg        <= dead_next;
            time_reg        <= time_next;
        end
    end

endmodule

/* hdl/battery_soc_smoothing_filter_unit.sv */
`timescale 1ns / 1ps

// State-of-charge smoothing filter. Each transfer on the input stream is either
// a gauge sample (tuser low) or a charger event (tuser high) and produces exactly
// one result transfer. An accepted item sits in an input register; the whole smoothing
// step, including the 32-bit time accumulation and the threshold compares, runs in a
// single pass from that register into the result register, where the filter state is
// updated at the same edge. A result is offered once its item has moved from the input
// register into the result register, and one item per cycle is sustained as long as
// the output side keeps taking results. A stalled result holds the input register, so
// the input side stalls once one item waits behind it. Configuration registers take
// effect from the next item and should be written only while no item is in flight.

module battery_soc_smoothing_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_soc_word[15:0], cell_voltage_word[31:16], elapsed_ms[63:32],
    // charger_event[65:64], zero fill [71:66]
    input  logic [71:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reported_percent[6:0], supply_status[8:7], charge_level[10:9],
    // health_dead[11], percent_updated[12], notify[13], fast_poll[14], zero [15]
    output logic [15:0] m_axis_tdata,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    bsoc_pkg::cfg_t    cfg;
    bsoc_pkg::item_t   in_item_reg;
    logic              in_valid_reg;
    bsoc_pkg::result_t res;
    bsoc_pkg::result_t out_res_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    bsoc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bsoc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (in_item_reg),
        .advance (advance),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind              <= s_axis_tuser;
            in_item_reg.raw_soc_word      <= s_axis_tdata[15:0];
            in_item_reg.cell_voltage_word <= s_axis_tdata[31:16];
            in_item_reg.elapsed_ms        <= s_axis_tdata[63:32];
            in_item_reg.charger_event     <= s_axis_tdata[65:64];
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg};

endmodule

/* hdl/bsoc_checker.sv */
`timescale 1ns / 1ps

module bsoc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result transfer stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // fast poll follows the reported status
    a_fast_poll: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14] == (m_axis_tdata[8:7] != bsoc_pkg::ST_DISCHARGING)))
        else $error("fast poll does not match status");

    // full level only at full percent, full status only at full percent
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[10:9] == bsoc_pkg::LVL_FULL ||
                          m_axis_tdata[8:7] == bsoc_pkg::ST_FULL)
        |-> m_axis_tdata[6:0] == bsoc_pkg::FULL_PERCENT)
        else $error("full reported below full percent");

    // dead health only with critical level, percent never above full
    a_health_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[11] || m_axis_tdata[10:9] == bsoc_pkg::LVL_CRITICAL) &&
                          m_axis_tdata[6:0] <= bsoc_pkg::FULL_PERCENT)
        else $error("health, level or percent out of line");

endmodule

bind battery_soc_smoothing_filter_unit bsoc_checker u_bsoc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
